### rtl/csd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the CAN signal decoder.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FRAME_W     = 8 * FRAME_BYTES;
  localparam int LEN_W       = 7;
  localparam int START_W     = 6;
  localparam int FACTOR_W    = 32;
  localparam int OFFSET_W    = 48;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int PP_W        = 65;
  localparam int SUM_W       = 98;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [FRAME_W-1:0] ALL_ONES = '1;
  localparam logic [FRAME_W-1:0] PHYS_MAX = {1'b0, {(FRAME_W-1){1'b1}}};
  localparam logic [FRAME_W-1:0] PHYS_MIN = {1'b1, {(FRAME_W-1){1'b0}}};

  localparam logic [LEN_W-1:0]    RST_BIT_LENGTH   = 7'd8;
  localparam logic [FACTOR_W-1:0] RST_SCALE_FACTOR = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BIT    = 3'd0,
    REG_BIT_LENGTH   = 3'd1,
    REG_BIG_ENDIAN   = 3'd2,
    REG_SIGNED_VALUE = 3'd3,
    REG_SCALE_FACTOR = 3'd4,
    REG_SCALE_OFFSET = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [START_W-1:0]  start_bit;
    logic [LEN_W-1:0]    bit_length;
    logic                big_endian;
    logic                signed_value;
    logic [FACTOR_W-1:0] scale_factor;
    logic [OFFSET_W-1:0] scale_offset;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] raw;
    logic               oof;
  } item_t;

endpackage

### rtl/csd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_front
// Accepts frames, extracts the configured signal bits in Intel or Motorola
// order, masks, sign-extends and flags bits outside the frame.
// ----------------------------------------------------------------------------
module csd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csd_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [csd_pkg::FRAME_W-1:0]   frame_data_i,
  input  logic                          fifo_full_i,
  output logic                          push_o,
  output csd_pkg::item_t                item_o
);
  import csd_pkg::*;

  logic               fe_valid_q, fe_valid_d;
  item_t              item_q;
  logic [LEN_W-1:0]   len;
  logic [START_W-1:0] eff_start;
  logic [LEN_W:0]     end_pos;
  logic [FRAME_W-1:0] rev, src, shifted, mask;
  logic               sign_bit;
  item_t              item_d;
  logic               accept;

  always_comb begin
    for (int b = 0; b < FRAME_BYTES; b++) begin
      rev[8*b +: 8] = frame_data_i[8*(FRAME_BYTES-1-b) +: 8];
    end
  end

  // Motorola: byte-reverse the frame, then bits run upward like Intel
  always_comb begin
    len       = (cfg_i.bit_length > LEN_W'(FRAME_W)) ? LEN_W'(FRAME_W) : cfg_i.bit_length;
    eff_start = cfg_i.big_endian ? {~cfg_i.start_bit[5:3], cfg_i.start_bit[2:0]}
                                 : cfg_i.start_bit;
    src       = cfg_i.big_endian ? rev : frame_data_i;
    shifted   = src >> eff_start;
    end_pos   = {2'b00, eff_start} + {1'b0, len};
    mask      = len[LEN_W-1] ? ALL_ONES : ~(ALL_ONES << len[START_W-1:0]);
    sign_bit  = shifted[len[START_W-1:0] - START_W'(1)];
    item_d.raw = shifted & mask;
    item_d.oof = (len != '0) && (end_pos > (LEN_W+1)'(FRAME_W));
    if (cfg_i.signed_value && !len[LEN_W-1] && (len != '0) && sign_bit) begin
      item_d.raw = item_d.raw | ~mask;
    end
  end

  assign in_ready_o = !fe_valid_q || !fifo_full_i;
  assign push_o     = fe_valid_q && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fe_valid_d = accept || (fe_valid_q && !push_o);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else begin
      fe_valid_q <= fe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/csd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_fifo
// Short register queue between the extraction front and the scaling back.
// ----------------------------------------------------------------------------
module csd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  csd_pkg::item_t  data_i,
  input  logic            pop_i,
  output csd_pkg::item_t  data_o,
  output logic            full_o,
  output logic            empty_o
);
  import csd_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/csd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_back
// Scaling pipeline: split multiply, offset add, saturation, output register.
// ----------------------------------------------------------------------------
module csd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csd_pkg::cfg_t               cfg_i,
  input  logic                        fifo_empty_i,
  input  csd_pkg::item_t              item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [csd_pkg::FRAME_W-1:0] raw_value_o,
  output logic [csd_pkg::FRAME_W-1:0] scaled_value_o,
  output logic                        saturated_o,
  output logic                        out_of_frame_o
);
  import csd_pkg::*;

  logic                    adv;
  logic                    s1_valid_q, s2_valid_q, out_valid_q;
  logic                    sx;
  logic signed [PP_W-1:0]  pp_lo_d, pp_hi_d, pp_lo_q, pp_hi_q;
  item_t                   s1_item_q, s2_item_q;
  logic [SUM_W-1:0]        sum_d, sum_q;
  logic                    sat_d;
  logic [FRAME_W-1:0]      phys_d;
  logic [FRAME_W-1:0]      raw_q, phys_q;
  logic                    sat_q, oof_q;

  // whole pipeline moves together when the output slot frees up
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !fifo_empty_i;
  assign sx    = cfg_i.signed_value && item_i.raw[FRAME_W-1];

  always_comb begin
    pp_lo_d = $signed({1'b0, item_i.raw[31:0]}) * $signed(cfg_i.scale_factor);
    pp_hi_d = $signed({sx, item_i.raw[63:32]}) * $signed(cfg_i.scale_factor);
  end

  always_comb begin
    sum_d = {pp_hi_q[PP_W-1], pp_hi_q, 32'b0}
          + {{(SUM_W-PP_W){pp_lo_q[PP_W-1]}}, pp_lo_q}
          + {{(SUM_W-OFFSET_W){cfg_i.scale_offset[OFFSET_W-1]}}, cfg_i.scale_offset};
  end

  always_comb begin
    sat_d  = (sum_q[SUM_W-1:FRAME_W-1] != '0) && (sum_q[SUM_W-1:FRAME_W-1] != '1);
    phys_d = sum_q[FRAME_W-1:0];
    if (sat_d) begin
      phys_d = sum_q[SUM_W-1] ? PHYS_MIN : PHYS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_lo_q   <= pp_lo_d;
      pp_hi_q   <= pp_hi_d;
      s1_item_q <= item_i;
      sum_q     <= sum_d;
      s2_item_q <= s1_item_q;
      raw_q     <= s2_item_q.raw;
      oof_q     <= s2_item_q.oof;
      phys_q    <= phys_d;
      sat_q     <= sat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_q;
  assign scaled_value_o = phys_q;
  assign saturated_o    = sat_q;
  assign out_of_frame_o = oof_q;

endmodule

### rtl/can_signal_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_decoder_top
// Path: input beat, front register, queue, multiply stage, add stage, output
//   register, out_valid_o. Throughput: one frame per cycle while out_ready_i
//   is high, set by the fully pipelined scaling back end.
// Reset: rst_ni asynchronous active low; clears all valids and the queue and
//   loads the configuration defaults (length 8, factor 1.0).
// ----------------------------------------------------------------------------
module can_signal_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [csd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [csd_pkg::FRAME_W-1:0]    frame_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [csd_pkg::FRAME_W-1:0]    raw_value_o,
  output logic signed [csd_pkg::FRAME_W-1:0] scaled_value_o,
  output logic                           saturated_o,
  output logic                           out_of_frame_o
);
  import csd_pkg::*;

  cfg_t               cfg_q;
  item_t              fe_item, fifo_item;
  logic               push, pop, fifo_full, fifo_empty;
  logic [FRAME_W-1:0] phys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_bit    <= '0;
      cfg_q.bit_length   <= RST_BIT_LENGTH;
      cfg_q.big_endian   <= 1'b0;
      cfg_q.signed_value <= 1'b0;
      cfg_q.scale_factor <= RST_SCALE_FACTOR;
      cfg_q.scale_offset <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_BIT:    cfg_q.start_bit    <= cfg_wdata_i[START_W-1:0];
        REG_BIT_LENGTH:   cfg_q.bit_length   <= cfg_wdata_i[LEN_W-1:0];
        REG_BIG_ENDIAN:   cfg_q.big_endian   <= cfg_wdata_i[0];
        REG_SIGNED_VALUE: cfg_q.signed_value <= cfg_wdata_i[0];
        REG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_wdata_i[FACTOR_W-1:0];
        REG_SCALE_OFFSET: cfg_q.scale_offset <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  csd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .frame_data_i (frame_data_i),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .item_o       (fe_item)
  );

  csd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fe_item),
    .pop_i   (pop),
    .data_o  (fifo_item),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  csd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .fifo_empty_i   (fifo_empty),
    .item_i         (fifo_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .raw_value_o    (raw_value_o),
    .scaled_value_o (phys),
    .saturated_o    (saturated_o),
    .out_of_frame_o (out_of_frame_o)
  );

  assign scaled_value_o = $signed(phys);

endmodule

### rtl/csd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks of the CAN signal decoder, bound to the top level.
// ----------------------------------------------------------------------------
module csd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [csd_pkg::FRAME_W-1:0] raw_value_o,
  input logic [csd_pkg::FRAME_W-1:0] scaled_value_o,
  input logic                        saturated_o,
  input logic                        out_of_frame_o
);
  import csd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(raw_value_o) && $stable(scaled_value_o)
      && $stable(saturated_o) && $stable(out_of_frame_o))
    else $error("result payload changed while stalled");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> scaled_value_o == PHYS_MAX
      || scaled_value_o == PHYS_MIN)
    else $error("saturated result not at a bound");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

endmodule

bind can_signal_decoder_top csd_checker u_csd_checker (.*);

### tb/can_signal_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_decoder_top_tb
// Self-checking bench for the CAN signal decoder. A queue-fed driver sends
// frames and a monitor checks each decoded beat against a local decode model.
// The model covers bit placement, sign extension and saturating Q48.16
// scaling. A directed set of corner frames runs first, then randomly
// configured phases, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module can_signal_decoder_top_tb;
  import csd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 30;
  localparam int PHASE_FRAMES = 50;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [FRAME_W-1:0] raw;
    logic [FRAME_W-1:0] phys;
    logic               sat;
    logic               oof;
  } decoded_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FRAME_W-1:0]    frame_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [FRAME_W-1:0]    raw_value_o;
  logic signed [FRAME_W-1:0] scaled_value_o;
  logic                  saturated_o;
  logic                  out_of_frame_o;

  cfg_t               active_cfg;
  logic [FRAME_W-1:0] frames_to_send[$];
  decoded_t           pending_decodes[$];
  bit                 quiet_phase = 1'b0;
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 error_count = 0;
  int                 frames_sent = 0;
  int                 config_count = 0;
  int                 sat_count = 0;
  int                 oof_count = 0;
  int                 cycle_count = 0;

  can_signal_decoder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_data_i    (frame_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .raw_value_o     (raw_value_o),
    .scaled_value_o  (scaled_value_o),
    .saturated_o     (saturated_o),
    .out_of_frame_o  (out_of_frame_o)
  );

  always #5 clk_i = ~clk_i;

  // {outside, byte}
  function automatic logic [8:0] frame_byte(input logic [FRAME_W-1:0] f, input int idx);
    if (idx < 0 || idx >= FRAME_BYTES) return {1'b1, 8'h00};
    return {1'b0, f[8*idx +: 8]};
  endfunction

  function automatic decoded_t decode_frame(input logic [FRAME_W-1:0] f);
    decoded_t d;
    int len, idx, sib, shift, dir;
    logic [8:0] fb;
    logic [FRAME_W-1:0] raw, mask;
    logic oof;
    logic signed [FRAME_W+1:0] raw_s;
    logic signed [129:0] a, b, c, total;
    raw = '0;
    oof = 1'b0;
    len = (active_cfg.bit_length > 64) ? 64 : int'(active_cfg.bit_length);
    if (len > 0) begin
      idx = int'(active_cfg.start_bit >> 3);
      sib = int'(active_cfg.start_bit[2:0]);
      shift = 8 - sib;
      dir = active_cfg.big_endian ? -1 : 1;
      fb = frame_byte(f, idx);
      oof |= fb[8];
      raw = 64'(fb[7:0]) >> sib;
      while (shift < len) begin
        idx += dir;
        fb = frame_byte(f, idx);
        oof |= fb[8];
        raw |= 64'(fb[7:0]) << shift;
        shift += 8;
      end
      if (len < 64) begin
        mask = (64'd1 << len) - 64'd1;
        raw &= mask;
        if (active_cfg.signed_value && raw[len-1]) raw |= ~mask;
      end
    end
    raw_s = active_cfg.signed_value ? {{2{raw[63]}}, raw} : {2'b00, raw};
    a = 130'(raw_s);
    b = 130'($signed(active_cfg.scale_factor));
    c = 130'($signed(active_cfg.scale_offset));
    total = a * b + c;
    d.raw = raw;
    d.oof = oof;
    d.sat = !((&total[129:63]) || !(|total[129:63]));
    d.phys = d.sat ? (total[129] ? PHYS_MIN : PHYS_MAX) : total[63:0];
    return d;
  endfunction

  function automatic int pick_idle();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FRAME_W-1:0] random_frame();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_decodes.push_back(decode_frame(frame_data_i));
        frames_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          in_valid_i <= 1'b1;
          frame_data_i <= frames_to_send.pop_front();
          gap_left = pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_decodes.size() == 0) begin
          $error("unexpected result beat: raw_value %h", raw_value_o);
          error_count++;
        end else begin
          want = pending_decodes.pop_front();
          sat_count += want.sat;
          oof_count += want.oof;
          if (raw_value_o !== want.raw) begin
            $error("raw_value expected %h actual %h", want.raw, raw_value_o);
            error_count++;
          end
          if (scaled_value_o !== want.phys) begin
            $error("scaled_value expected %h actual %h", want.phys, scaled_value_o);
            error_count++;
          end
          if (saturated_o !== want.sat) begin
            $error("saturated expected %b actual %b", want.sat, saturated_o);
            error_count++;
          end
          if (out_of_frame_o !== want.oof) begin
            $error("out_of_frame expected %b actual %b", want.oof, out_of_frame_o);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_BIT:    active_cfg.start_bit = val[START_W-1:0];
      REG_BIT_LENGTH:   active_cfg.bit_length = val[LEN_W-1:0];
      REG_BIG_ENDIAN:   active_cfg.big_endian = val[0];
      REG_SIGNED_VALUE: active_cfg.signed_value = val[0];
      REG_SCALE_FACTOR: active_cfg.scale_factor = val[FACTOR_W-1:0];
      REG_SCALE_OFFSET: active_cfg.scale_offset = val[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry junk; the block must ignore them
  task automatic load_config(input logic [START_W-1:0] s, input logic [LEN_W-1:0] l,
                             input logic be, input logic sv,
                             input logic [FACTOR_W-1:0] f, input logic [OFFSET_W-1:0] o);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_START_BIT, {junk[CFG_DATA_W-1:START_W], s});
    write_reg(REG_BIT_LENGTH, {junk[CFG_DATA_W-1:LEN_W], l});
    write_reg(REG_BIG_ENDIAN, {junk[CFG_DATA_W-1:1], be});
    write_reg(REG_SIGNED_VALUE, {junk[CFG_DATA_W-2:0], sv});
    write_reg(REG_SCALE_FACTOR, {junk[CFG_DATA_W-1:FACTOR_W], f});
    write_reg(REG_SCALE_OFFSET, o);
    config_count++;
  endtask

  task automatic random_config();
    logic [LEN_W-1:0] l;
    logic [FACTOR_W-1:0] f;
    logic [OFFSET_W-1:0] o;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) l = '0;
    else if (r == 1) l = LEN_W'($urandom_range(65, 127));
    else if (r < 5) l = 7'd64;
    else l = LEN_W'($urandom_range(1, 64));
    case ($urandom_range(0, 9))
      0: f = 32'h8000_0000;
      1: f = 32'h7FFF_FFFF;
      2: f = '0;
      3, 4: f = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: f = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0: o = 48'h8000_0000_0000;
      1: o = 48'h7FFF_FFFF_FFFF;
      2: o = '0;
      3, 4: o = 48'($urandom_range(0, 32'h0010_0000)) - 48'h0008_0000;
      default: o = 48'({$urandom, $urandom});
    endcase
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_A, CFG_DATA_W'({$urandom, $urandom}));
    load_config(START_W'($urandom_range(0, 63)), l, 1'($urandom), 1'($urandom), f, o);
  endtask

  // sampled at the falling edge so every update of the rising edge is seen
  task automatic drain();
    while (frames_to_send.size() > 0 || in_valid_i || pending_decodes.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    active_cfg = '{start_bit: '0, bit_length: RST_BIT_LENGTH, big_endian: 1'b0,
                   signed_value: 1'b0, scale_factor: RST_SCALE_FACTOR, scale_offset: '0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration
    frames_to_send.push_back('0);
    frames_to_send.push_back(ALL_ONES);
    frames_to_send.push_back(64'h0123_4567_89AB_CDEF);
    drain();
    // full width unsigned, positive clip
    load_config(6'd0, 7'd64, 1'b0, 1'b0, RST_SCALE_FACTOR, '0);
    frames_to_send.push_back(ALL_ONES);
    frames_to_send.push_back(64'h0000_7FFF_FFFF_FFFF);
    drain();
    // most negative factor times most negative raw, max offset
    load_config(6'd0, 7'd64, 1'b0, 1'b1, 32'h8000_0000, 48'h7FFF_FFFF_FFFF);
    frames_to_send.push_back(64'h8000_0000_0000_0000);
    frames_to_send.push_back(ALL_ONES);
    drain();
    // negative clip
    load_config(6'd0, 7'd64, 1'b0, 1'b1, 32'h7FFF_FFFF, 48'h8000_0000_0000);
    frames_to_send.push_back(64'h8000_0000_0000_0000);
    drain();
    // Motorola inside the frame
    load_config(6'd60, 7'd16, 1'b1, 1'b1, RST_SCALE_FACTOR, '0);
    frames_to_send.push_back(ALL_ONES);
    frames_to_send.push_back(64'hF0A5_0000_0000_0000);
    drain();
    // Motorola running below byte 0
    load_config(6'd4, 7'd20, 1'b1, 1'b0, RST_SCALE_FACTOR, '0);
    frames_to_send.push_back(ALL_ONES);
    drain();
    // Intel running past the last byte
    load_config(6'd60, 7'd12, 1'b0, 1'b1, RST_SCALE_FACTOR, '0);
    frames_to_send.push_back(ALL_ONES);
    drain();
    // zero length gives the offset alone
    load_config(6'd5, 7'd0, 1'b0, 1'b1, 32'h0003_0000, 48'h8000_0000_0000);
    frames_to_send.push_back(ALL_ONES);
    drain();
    // length above 64
    load_config(6'd5, 7'd127, 1'b0, 1'b0, 32'h0000_0001, 48'h7FFF_FFFF_FFFF);
    frames_to_send.push_back(ALL_ONES);
    frames_to_send.push_back(64'hDEAD_BEEF_CAFE_F00D);
    drain();
    // single signed bit, factor -1.0
    load_config(6'd63, 7'd1, 1'b1, 1'b1, 32'hFFFF_0000, 48'h0000_0000_1234);
    frames_to_send.push_back(ALL_ONES);
    frames_to_send.push_back('0);
    drain();
    // zero factor; writes to unused indexes must change nothing
    write_reg(REG_SPARE_A, CFG_DATA_W'({$urandom, $urandom}));
    write_reg(REG_SPARE_B, CFG_DATA_W'({$urandom, $urandom}));
    load_config(6'd7, 7'd65, 1'b1, 1'b1, '0, 48'hFFFF_FFFF_FFFF);
    frames_to_send.push_back({32{2'b10}});
    frames_to_send.push_back({32{2'b01}});
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      quiet_phase = (p % 5 == 2);
      random_config();
      for (int i = 0; i < PHASE_FRAMES; i++) frames_to_send.push_back(random_frame());
      drain();
    end

    quiet_phase = 1'b0;
    load_config(6'd63, 7'd64, 1'b1, 1'b1, 32'h8000_0000, 48'h8000_0000_0000);
    for (int i = 0; i < PHASE_FRAMES / 2; i++) frames_to_send.push_back(random_frame());
    drain();
    load_config(6'd0, 7'd1, 1'b0, 1'b0, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF);
    for (int i = 0; i < PHASE_FRAMES / 2; i++) frames_to_send.push_back(random_frame());
    drain();

    $display("Decoded %0d frames under %0d register settings.", frames_sent, config_count);
    $display("%0d results clipped, %0d touched bytes outside the frame.", sat_count, oof_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csd_pkg.sv
rtl/csd_front.sv
rtl/csd_fifo.sv
rtl/csd_back.sv
rtl/can_signal_decoder_top.sv
rtl/csd_checker.sv
tb/can_signal_decoder_top_tb.sv
